// ===== sv/triangle_area_reciprocal_defines.svh =====
// Shared assertion macros for the triangle area block
`ifndef TRIANGLE_AREA_RECIPROCAL_DEFINES_SVH
`define TRIANGLE_AREA_RECIPROCAL_DEFINES_SVH

// Check a property while out of reset
`define TAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every edge, reset included
`define TAR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/tar_pkg.sv =====
package tar_pkg;

  // Fraction bits dropped from each cross product component
  localparam int FRACTION_SHIFT = 8;

  localparam int VW = 16;                  // vertex coordinate width
  localparam int EW = VW + 1;              // edge component width
  localparam int PW = 2 * EW;              // product width
  localparam int XW = PW + 1;              // cross component width
  localparam int CW = XW - FRACTION_SHIFT; // shifted component / magnitude width
  localparam int RW = CW + 1;              // root width
  localparam int SW = 2 * RW;              // sum of squares width
  localparam int ONE_SHIFT = 12;           // 0x1000
  localparam int XPW = 5;                  // scale exponent width
  localparam int DW = ONE_SHIFT - FRACTION_SHIFT + (1 << XPW); // reduced dividend width
  localparam int EXW = $clog2(DW);         // dividend exponent width
  localparam int QW = 16;                  // kept quotient bits

  // Operation codes
  localparam logic [1:0] OP_SIZE    = 2'd0;
  localparam logic [1:0] OP_NORMAL  = 2'd1;
  localparam logic [1:0] OP_LOWPOLY = 2'd2;

  // Size classes
  localparam logic [QW-1:0] SIZE_SMALL = QW'(17);
  localparam logic [QW-1:0] SIZE_LARGE = QW'(18);
  localparam int LEN_LIMIT_LOG = 17;

  // Item attributes carried alongside the data path
  typedef struct packed {
    logic [1:0]     op;
    logic [XPW-1:0] ex;
    logic           zero;
    logic           big;
  } side_t;

endpackage

// ===== sv/triangle_area_reciprocal.sv =====
// Channel   Direction  Width  Contents
// s_axis    in         152+2  tdata: vertices and exponent, tuser: op
// m_axis    out        16+1   tdata: value, tuser: zero_area
//
// One item enters per cycle unless a result waits; it passes the front stages,
// the root stages, the divider stages and the output register (root stages
// follow the root width, divider stages the dividend width). Synchronous reset
// empties the pipeline; items in flight are dropped. The whole pipeline holds
// while a result waits at the output; s_tready is low only then.
module triangle_area_reciprocal (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z,
  // third_x, third_y, third_z, scale_exponent, zero pad
  input  logic [151:0] s_tdata,
  input  logic [1:0]   s_tuser,   // op
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [15:0]  m_tdata,   // value
  output logic         m_tuser    // zero_area
);

  localparam int VW  = tar_pkg::VW;
  localparam int EW  = tar_pkg::EW;
  localparam int PW  = tar_pkg::PW;
  localparam int XW  = tar_pkg::XW;
  localparam int CW  = tar_pkg::CW;
  localparam int RW  = tar_pkg::RW;
  localparam int SW  = tar_pkg::SW;
  localparam int QW  = tar_pkg::QW;
  localparam int XPW = tar_pkg::XPW;
  localparam int F   = tar_pkg::FRACTION_SHIFT;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Input unpacking
  logic signed [VW-1:0] p1 [3];
  logic signed [VW-1:0] p2 [3];
  logic signed [VW-1:0] p3 [3];
  tar_pkg::side_t       side_in;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      p1[j] = s_tdata[VW*j +: VW];
      p2[j] = s_tdata[VW*(3+j) +: VW];
      p3[j] = s_tdata[VW*(6+j) +: VW];
    end
    side_in.op   = s_tuser;
    side_in.ex   = s_tdata[VW*9 +: XPW];
    side_in.zero = 1'b0;
    side_in.big  = 1'b0;
  end

  // Stage 1: edges, halved toward zero in low-poly mode
  logic signed [EW-1:0] ea [3];
  logic signed [EW-1:0] eb [3];
  logic                 v1;
  tar_pkg::side_t       sd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [EW-1:0] da;
    logic signed [EW-1:0] db;
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        da = EW'(p1[j]) - EW'(p2[j]);
        db = EW'(p3[j]) - EW'(p1[j]);
        if (s_tuser == tar_pkg::OP_LOWPOLY) begin
          ea[j] <= (da + $signed(EW'(da[EW-1]))) >>> 1;
          eb[j] <= (db + $signed(EW'(db[EW-1]))) >>> 1;
        end else begin
          ea[j] <= da;
          eb[j] <= db;
        end
      end
      sd1 <= side_in;
    end
  end

  // Stage 2: six cross products
  logic signed [PW-1:0] pr [6];
  logic                 v2;
  tar_pkg::side_t       sd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr[0] <= ea[1] * eb[2];
      pr[1] <= ea[2] * eb[1];
      pr[2] <= ea[2] * eb[0];
      pr[3] <= ea[0] * eb[2];
      pr[4] <= ea[0] * eb[1];
      pr[5] <= ea[1] * eb[0];
      sd2   <= sd1;
    end
  end

  // Stage 3: component differences, floor shift by dropping low bits
  logic signed [CW-1:0] cx [3];
  logic                 v3;
  tar_pkg::side_t       sd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [XW-1:0] df;
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        df    = XW'(pr[2*j]) - XW'(pr[2*j+1]);
        cx[j] <= df[XW-1:F];
      end
      sd3 <= sd2;
    end
  end

  // Stage 4: magnitudes
  logic [CW-1:0]  mg [3];
  logic           v4;
  tar_pkg::side_t sd4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        mg[j] <= cx[j][CW-1] ? (~cx[j] + CW'(1)) : cx[j];
      end
      sd4 <= sd3;
    end
  end

  // Stage 5: squares
  logic [2*CW-1:0] sq [3];
  logic            v5;
  tar_pkg::side_t  sd5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        sq[j] <= mg[j] * mg[j];
      end
      sd5 <= sd4;
    end
  end

  // Stage 6: first partial sum
  logic [2*CW:0]   ps01;
  logic [2*CW-1:0] ps2;
  logic            v6;
  tar_pkg::side_t  sd6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ps01 <= (2*CW+1)'(sq[0]) + (2*CW+1)'(sq[1]);
      ps2  <= sq[2];
      sd6  <= sd5;
    end
  end

  // Stage 7: full sum of squares
  logic [SW-1:0]  sum;
  logic           v7;
  tar_pkg::side_t sd7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= SW'(ps01) + SW'(ps2);
      sd7 <= sd6;
    end
  end

  // Square root pipeline
  logic           rt_valid;
  logic [RW-1:0]  rt_root;
  tar_pkg::side_t rt_side;

  tar_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .in_rad    (sum),
    .in_side   (sd7),
    .out_valid (rt_valid),
    .out_root  (rt_root),
    .out_side  (rt_side)
  );

  // Classify the length on its way into the divider
  tar_pkg::side_t dv_side;
  logic [RW+F-1:0] len;

  always_comb begin
    len          = {rt_root, F'(0)};
    dv_side      = rt_side;
    dv_side.zero = (rt_root == '0);
    dv_side.big  = (len > (RW+F)'(1 << tar_pkg::LEN_LIMIT_LOG));
  end

  // Reciprocal pipeline
  logic           dq_valid;
  logic [QW-1:0]  dq_quot;
  tar_pkg::side_t dq_side;

  tar_recip u_recip (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (rt_valid),
    .in_div    (rt_root),
    .in_side   (dv_side),
    .out_valid (dq_valid),
    .out_quot  (dq_quot),
    .out_side  (dq_side)
  );

  // Output register: pick the result for the mode
  logic [QW-1:0] value_next;

  always_comb begin
    if (dq_side.op == tar_pkg::OP_SIZE) begin
      value_next = dq_side.big ? tar_pkg::SIZE_LARGE : tar_pkg::SIZE_SMALL;
    end else if (dq_side.zero) begin
      value_next = '0;
    end else begin
      value_next = dq_quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= value_next;
      m_tuser <= dq_side.zero;
    end
  end

endmodule

// ===== sv/tar_isqrt.sv =====
// Pipelined integer square root, one result bit per stage
module tar_isqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [tar_pkg::SW-1:0]   in_rad,
  input  tar_pkg::side_t           in_side,
  output logic                     out_valid,
  output logic [tar_pkg::RW-1:0]   out_root,
  output tar_pkg::side_t           out_side
);

  localparam int RW = tar_pkg::RW;
  localparam int SW = tar_pkg::SW;

  logic                vld  [RW];
  logic [SW-1:0]       rad  [RW];
  logic [RW+1:0]       rem  [RW];
  logic [RW-1:0]       root [RW];
  tar_pkg::side_t      side [RW];

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic           v_i;
    logic [SW-1:0]  rad_i;
    logic [RW+1:0]  rem_i;
    logic [RW-1:0]  root_i;
    tar_pkg::side_t side_i;
    logic [RW+1:0]  rem_sh;
    logic [RW+1:0]  trial;
    logic           fit;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rad_i  = in_rad;
      assign rem_i  = '0;
      assign root_i = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = vld[k-1];
      assign rad_i  = rad[k-1];
      assign rem_i  = rem[k-1];
      assign root_i = root[k-1];
      assign side_i = side[k-1];
    end

    // Bring in two radicand bits and try the next root bit
    always_comb begin
      rem_sh = {rem_i[RW-1:0], rad_i[SW-1 -: 2]};
      trial  = {root_i, 2'b01};
      fit    = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[k]  <= {rad_i[SW-3:0], 2'b00};
        rem[k]  <= fit ? (rem_sh - trial) : rem_sh;
        root[k] <= {root_i[RW-2:0], fit};
        side[k] <= side_i;
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign out_root  = root[RW-1];
  assign out_side  = side[RW-1];

endmodule

// ===== sv/tar_recip.sv =====
// Pipelined restoring divider of a power of two by the root, one quotient bit per stage
module tar_recip (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [tar_pkg::RW-1:0]   in_div,
  input  tar_pkg::side_t           in_side,
  output logic                     out_valid,
  output logic [tar_pkg::QW-1:0]   out_quot,
  output tar_pkg::side_t           out_side
);

  localparam int RW  = tar_pkg::RW;
  localparam int DW  = tar_pkg::DW;
  localparam int QW  = tar_pkg::QW;
  localparam int EXW = tar_pkg::EXW;

  logic                vld  [DW];
  logic [RW-1:0]       dvs  [DW];
  logic [RW:0]         rem  [DW];
  logic [QW-1:0]       quot [DW];
  tar_pkg::side_t      side [DW];

  for (genvar k = 0; k < DW; k++) begin : g_step
    logic           v_i;
    logic [RW-1:0]  dvs_i;
    logic [RW:0]    rem_i;
    logic [QW-1:0]  quot_i;
    tar_pkg::side_t side_i;
    logic [EXW-1:0] pos;
    logic [RW:0]    rem_sh;
    logic           fit;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign dvs_i  = in_div;
      assign rem_i  = '0;
      assign quot_i = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = vld[k-1];
      assign dvs_i  = dvs[k-1];
      assign rem_i  = rem[k-1];
      assign quot_i = quot[k-1];
      assign side_i = side[k-1];
    end

    // Dividend is a single set bit; shift in that bit when this step reaches it
    always_comb begin
      pos    = EXW'(tar_pkg::ONE_SHIFT - tar_pkg::FRACTION_SHIFT) + EXW'(side_i.ex);
      rem_sh = {rem_i[RW-1:0], (pos == EXW'(DW - 1 - k))};
      fit    = (rem_sh >= {1'b0, dvs_i});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dvs[k]  <= dvs_i;
        rem[k]  <= fit ? (rem_sh - {1'b0, dvs_i}) : rem_sh;
        quot[k] <= {quot_i[QW-2:0], fit};
        side[k] <= side_i;
      end
    end
  end

  assign out_valid = vld[DW-1];
  assign out_quot  = quot[DW-1];
  assign out_side  = side[DW-1];

endmodule

// ===== sv/tar_checker.sv =====
`include "triangle_area_reciprocal_defines.svh"

// Port-level checks for the triangle area block
module tar_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [151:0] s_tdata,
  input logic [1:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [15:0]  m_tdata,
  input logic         m_tuser
);

  // A waiting result holds its value
  `TAR_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // Reset empties the output
  `TAR_ASSERT_ALWAYS(a_rst_empty, rst |=> !m_tvalid, "result present after reset")

  // Input side is open whenever the output is free
  `TAR_ASSERT(a_ready_free, !m_tvalid || m_tready |-> s_tready, "input blocked with free output")

  // A zero-length result carries zero or the small size class
  `TAR_ASSERT(a_zero_value, m_tvalid && m_tuser |-> m_tdata == 16'd0 || m_tdata == 16'd17, "bad value for zero length")

endmodule

bind triangle_area_reciprocal tar_checker u_tar_checker (.*);
